>>> rtl/core/btpc_pkg.sv
// ----------------------------------------------------------------------------
// btpc_pkg
// Shared types, constants and helpers for the barometric compensation core.
// ----------------------------------------------------------------------------
`default_nettype none

package btpc_pkg;

  localparam int unsigned DivSteps = 32;

  // configuration register indexes
  localparam logic [1:0] CfgASigned   = 2'd0;
  localparam logic [1:0] CfgAUnsigned = 2'd1;
  localparam logic [1:0] CfgBPair     = 2'd2;
  localparam logic [1:0] CfgMPair     = 2'd3;

  localparam logic [47:0] ASignedRst   = 48'd1756636956625;
  localparam logic [47:0] AUnsignedRst = 48'd140623671024241;
  localparam logic [31:0] BPairRst     = 32'd405667844;
  localparam logic [31:0] MPairRst     = 32'd3724086068;

  localparam logic [31:0] TempOffset = 32'd4000;
  localparam logic [31:0] PressScale = 32'd50000;
  localparam logic [31:0] B4Bias     = 32'd32768;
  localparam logic [31:0] PolyC1     = 32'd3038;
  localparam logic [31:0] PolyC2     = 32'hFFFF_E343; // -7357
  localparam logic [31:0] PolyC3     = 32'd3791;

  typedef struct packed {
    logic        want;
    logic        tzero;
    logic        bzero;
    logic        fix;
    logic [15:0] up;
    logic [31:0] tval;
  } side_t;

  typedef struct packed {
    logic        vld;
    logic [31:0] rem;
    logic [31:0] num;
    logic [31:0] den;
    logic [31:0] quo;
    side_t       side;
  } div_t;

  function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned n);
    return $unsigned($signed(v) >>> n);
  endfunction

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/btpc_div_cell.sv
// ----------------------------------------------------------------------------
// btpc_div_cell
// One restoring division step: one quotient bit per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module btpc_div_cell import btpc_pkg::*; (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   en_i,
  input  div_t  d_i,
  output div_t  d_o
);

  logic [32:0] trial;
  logic        ge;
  div_t        nxt;
  logic        vld_q;
  div_t        pay_q;

  always_comb begin
    trial = {d_i.rem, d_i.num[31]};
    ge    = trial >= {1'b0, d_i.den};
    nxt   = d_i;
    nxt.rem = ge ? 32'(trial - {1'b0, d_i.den}) : trial[31:0];
    nxt.num = {d_i.num[30:0], 1'b0};
    nxt.quo = {d_i.quo[30:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= d_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pay_q <= nxt;
    end
  end

  always_comb begin
    d_o     = pay_q;
    d_o.vld = vld_q;
  end

endmodule

`default_nettype wire

>>> rtl/core/btpc_div_chain.sv
// ----------------------------------------------------------------------------
// btpc_div_chain
// Row of division cells: 32-bit unsigned quotient after the last cell.
// ----------------------------------------------------------------------------
`default_nettype none

module btpc_div_chain import btpc_pkg::*; (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   en_i,
  input  div_t  d_i,
  output div_t  d_o
);

  div_t link [DivSteps+1];

  assign link[0] = d_i;

  for (genvar g = 0; g < DivSteps; g++) begin : g_cell
    btpc_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .d_i    (link[g]),
      .d_o    (link[g+1])
    );
  end

  assign d_o = link[DivSteps];

endmodule

`default_nettype wire

>>> rtl/core/baro_temp_pressure_compensation.sv
// Pipeline: 78 register stages from the input transfer to the output register.
// Throughput: one item per cycle; the whole pipe advances whenever the output
// register is empty or being taken, so a stall at the output holds every stage.
// Each division is a row of 32 one-bit cells, one cell per quotient bit.
// Reset: valid bits cleared, calibration registers load factory defaults.
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation
// Integer temperature and pressure compensation, oversampling 0.
// ----------------------------------------------------------------------------
`default_nettype none

module baro_temp_pressure_compensation import btpc_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  // configuration writes
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [47:0] cfg_data_i,
  // sample input
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [15:0] raw_temperature_i,
  input  wire  [15:0] raw_pressure_i,
  input  wire         want_pressure_i,
  // result output
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic signed [15:0] temperature_tenths_o,
  output logic [17:0] pressure_pa_o,
  output logic        pressure_valid_o,
  output logic        divide_error_o
);

  // --------------------------------------------------------------------------
  // Calibration registers; always writable. The user must write them only while idle; the block does not enforce it.
  // --------------------------------------------------------------------------
  logic [47:0] cal_as_q, cal_au_q;
  logic [31:0] cal_b_q, cal_m_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_as_q <= ASignedRst;
      cal_au_q <= AUnsignedRst;
      cal_b_q  <= BPairRst;
      cal_m_q  <= MPairRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgASigned:   cal_as_q <= cfg_data_i;
        CfgAUnsigned: cal_au_q <= cfg_data_i;
        CfgBPair:     cal_b_q  <= cfg_data_i[31:0];
        CfgMPair:     cal_m_q  <= cfg_data_i[31:0];
        default:      cal_m_q  <= cal_m_q;
      endcase
    end
  end

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = sext16(cal_as_q[47:32]);
  assign ac2 = sext16(cal_as_q[31:16]);
  assign ac3 = sext16(cal_as_q[15:0]);
  assign ac4 = {16'd0, cal_au_q[47:32]};
  assign ac5 = {16'd0, cal_au_q[31:16]};
  assign ac6 = {16'd0, cal_au_q[15:0]};
  assign b1  = sext16(cal_b_q[31:16]);
  assign b2  = sext16(cal_b_q[15:0]);
  assign mc  = sext16(cal_m_q[31:16]);
  assign md  = sext16(cal_m_q[15:0]);

  // Advance the whole pipe unless a finished result waits at the output.
  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // --------------------------------------------------------------------------
  // Valid bits, one per non-divider stage.
  // --------------------------------------------------------------------------
  logic v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q;
  logic v10_q, v11_q, v12_q;
  div_t o1, o2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q} <= '0;
      {v10_q, v11_q, v12_q} <= '0;
      out_valid_o <= 1'b0;
    end else if (adv) begin
      v0_q  <= in_valid_i;
      v1_q  <= v0_q;
      v2_q  <= v1_q;
      v3_q  <= o1.vld;
      v4_q  <= v3_q;
      v5_q  <= v4_q;
      v6_q  <= v5_q;
      v7_q  <= v6_q;
      v8_q  <= v7_q;
      v9_q  <= v8_q;
      v10_q <= o2.vld;
      v11_q <= v10_q;
      v12_q <= v11_q;
      out_valid_o <= v12_q;
    end
  end

  // --------------------------------------------------------------------------
  // Temperature front end: X1 and the signed divisor.
  // --------------------------------------------------------------------------
  logic [15:0] ut_q;
  side_t       s0_q, s1_q, s2_q;
  side_t       s0_d, s2_d;
  logic [31:0] prod1_q, an_q, ad_q;
  logic [31:0] x1_c, den_c, num_c;

  always_comb begin
    s0_d      = '0;
    s0_d.want = want_pressure_i;
    s0_d.up   = raw_pressure_i;
  end

  always_comb begin
    x1_c  = asr(prod1_q, 15);
    den_c = x1_c + md;
    num_c = {mc[20:0], 11'd0};
    s2_d       = s1_q;
    s2_d.tval  = x1_c;
    s2_d.tzero = (den_c == '0);
    s2_d.fix   = num_c[31] ^ den_c[31];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ut_q         <= raw_temperature_i;
      s0_q         <= s0_d;
      prod1_q      <= 32'(({16'd0, ut_q} - ac6) * ac5);
      s1_q         <= s0_q;
      s2_q         <= s2_d;
      an_q         <= num_c[31] ? 32'(0 - num_c) : num_c;
      ad_q         <= den_c[31] ? 32'(0 - den_c) : den_c;
    end
  end

  div_t d1;
  always_comb begin
    d1      = '0;
    d1.vld  = v2_q;
    d1.num  = an_q;
    d1.den  = ad_q;
    d1.side = s2_q;
  end

  btpc_div_chain u_tdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .d_i    (d1),
    .d_o    (o1)
  );

  // --------------------------------------------------------------------------
  // Temperature result and pressure coefficients B3, B4, B7.
  // --------------------------------------------------------------------------
  logic [31:0] x2_c, b5_c, t_c;
  logic [15:0] tsat_c;
  side_t       s3_d;

  always_comb begin
    x2_c = o1.side.fix ? 32'(0 - o1.quo) : o1.quo;
    b5_c = o1.side.tval + x2_c;
    t_c  = asr(b5_c + 32'd8, 4);
    if ($signed(t_c) > 32'sd32767) begin
      tsat_c = 16'h7FFF;
    end else if ($signed(t_c) < -32'sd32768) begin
      tsat_c = 16'h8000;
    end else begin
      tsat_c = t_c[15:0];
    end
    s3_d      = o1.side;
    s3_d.tval = sext16(tsat_c);
  end

  side_t       s3_q, s4_q, s5_q, s6_q, s7_q, s8_q, s9_q;
  side_t       s9_d;
  logic [31:0] b6_q, sqp_q, p2_q, p3_q, sq_q, x2a_q, x1b_q, x2a6_q, x1b6_q;
  logic [31:0] m1_q, m2_q, b3_q, x3b_q, m4_q, d7_q, b4_q, b7_q;
  logic [31:0] x3_c, b4_c;

  assign x3_c = asr(m1_q, 11) + x2a6_q;
  assign b4_c = m4_q >> 15;

  always_comb begin
    s9_d       = s8_q;
    s9_d.bzero = (b4_c == '0);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_q      <= s3_d;
      b6_q      <= b5_c - TempOffset;
      // square and linear products
      s4_q      <= s3_q;
      sqp_q     <= 32'(b6_q * b6_q);
      p2_q      <= 32'(ac2 * b6_q);
      p3_q      <= 32'(ac3 * b6_q);
      s5_q      <= s4_q;
      sq_q      <= asr(sqp_q, 12);
      x2a_q     <= asr(p2_q, 11);
      x1b_q     <= asr(p3_q, 13);
      s6_q      <= s5_q;
      m1_q      <= 32'(b2 * sq_q);
      m2_q      <= 32'(b1 * sq_q);
      x2a6_q    <= x2a_q;
      x1b6_q    <= x1b_q;
      s7_q      <= s6_q;
      b3_q      <= asr({ac1[29:0], 2'd0} + x3_c + 32'd2, 2);
      x3b_q     <= asr(x1b6_q + asr(m2_q, 16) + 32'd2, 2);
      s8_q      <= s7_q;
      m4_q      <= 32'(ac4 * (x3b_q + B4Bias));
      d7_q      <= {16'd0, s7_q.up} - b3_q;
      s9_q      <= s9_d;
      b7_q      <= 32'(d7_q * PressScale);
      b4_q      <= b4_c;
    end
  end

  // B7 below 2^31 divides after doubling, else doubles after dividing.
  div_t d2;
  always_comb begin
    d2          = '0;
    d2.vld      = v9_q;
    d2.num      = b7_q[31] ? b7_q : {b7_q[30:0], 1'b0};
    d2.den      = b4_q;
    d2.side     = s9_q;
    d2.side.fix = b7_q[31];
  end

  btpc_div_chain u_pdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .d_i    (d2),
    .d_o    (o2)
  );

  // --------------------------------------------------------------------------
  // Pressure polynomial correction and output register.
  // --------------------------------------------------------------------------
  side_t       s10_q, s11_q, s12_q;
  logic [31:0] p10_q, p11_q, p12_q, sq2_q, m7_q, y_q, x2p_q, sh_c;

  assign sh_c = asr(p10_q, 8);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s10_q <= o2.side;
      p10_q <= o2.side.fix ? {o2.quo[30:0], 1'b0} : o2.quo;
      s11_q <= s10_q;
      p11_q <= p10_q;
      sq2_q <= 32'(sh_c * sh_c);
      m7_q  <= 32'(PolyC2 * p10_q);
      s12_q <= s11_q;
      p12_q <= p11_q;
      y_q   <= 32'(sq2_q * PolyC1);
      x2p_q <= asr(m7_q, 16);
    end
  end

  logic [31:0] pf_c;
  logic [17:0] psat_c;
  logic        err_c;

  always_comb begin
    pf_c = p12_q + asr(asr(y_q, 16) + x2p_q + PolyC3, 4);
    if (pf_c[31]) begin
      psat_c = '0;
    end else if (pf_c > 32'd262143) begin
      psat_c = '1;
    end else begin
      psat_c = pf_c[17:0];
    end
    err_c = s12_q.tzero || (s12_q.want && s12_q.bzero);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      divide_error_o       <= err_c;
      temperature_tenths_o <= err_c ? '0 : s12_q.tval[15:0];
      pressure_pa_o        <= (err_c || !s12_q.want) ? '0 : psat_c;
      pressure_valid_o     <= !err_c && s12_q.want;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/btpc_checker.sv
// ----------------------------------------------------------------------------
// btpc_checker
// Port-level checks on the compensation core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module btpc_checker (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               in_ready_o,
  input wire               out_valid_o,
  input wire               out_ready_i,
  input wire signed [15:0] temperature_tenths_o,
  input wire        [17:0] pressure_pa_o,
  input wire               pressure_valid_o,
  input wire               divide_error_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pressure_pa_o)
      && $stable(temperature_tenths_o))
    else $error("result dropped or changed while stalled");

  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow output space");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_error_o |-> temperature_tenths_o == 16'sd0
      && pressure_pa_o == 18'd0 && !pressure_valid_o)
    else $error("division error result not zeroed");

  a_nopress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pressure_valid_o |-> pressure_pa_o == 18'd0)
    else $error("pressure nonzero without a computed value");

endmodule

bind baro_temp_pressure_compensation btpc_checker u_btpc_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_ready_o           (in_ready_o),
  .out_valid_o          (out_valid_o),
  .out_ready_i          (out_ready_i),
  .temperature_tenths_o (temperature_tenths_o),
  .pressure_pa_o        (pressure_pa_o),
  .pressure_valid_o     (pressure_valid_o),
  .divide_error_o       (divide_error_o)
);

`default_nettype wire

>>> bench/baro_temp_pressure_compensation_tb.sv
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_tb
// Streams raw sample pairs through the compensation core under randomized
// input gaps and output stalls, predicts every reading in the bench from the
// current calibration and checks each output transfer against the oldest one.
// ----------------------------------------------------------------------------
`default_nettype none

module baro_temp_pressure_compensation_tb import btpc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 100; // pipe depth is 78, leave margin

  typedef struct {
    logic        hold;   // pause marker: wait until every reading is back
    logic [15:0] ut;
    logic [15:0] up;
    logic        want;
  } sample_t;

  typedef struct {
    logic signed [15:0] temp;
    logic [17:0]        press;
    logic               press_vld;
    logic               div_err;
  } reading_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #6 clk_i = ~clk_i;

  // block ports
  logic        cfg_valid_i = 1'b0;
  logic [1:0]  cfg_index_i = CfgASigned;
  logic [47:0] cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic [15:0] raw_temperature_i = '0;
  logic [15:0] raw_pressure_i    = '0;
  logic        want_pressure_i   = 1'b0;
  logic        out_ready_i = 1'b0;
  wire         cfg_ready_o, in_ready_o, out_valid_o;
  wire signed [15:0] temperature_tenths_o;
  wire  [17:0] pressure_pa_o;
  wire         pressure_valid_o, divide_error_o;

  baro_temp_pressure_compensation dut (.*);

  // bench copy of the calibration registers
  logic [47:0] cal_a_signed   = ASignedRst;
  logic [47:0] cal_a_unsigned = AUnsignedRst;
  logic [31:0] cal_b          = BPairRst;
  logic [31:0] cal_m          = MPairRst;

  sample_t  pending_samples[$];
  reading_t expected_readings[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] shr_arith(input logic [31:0] v, input int n);
    return $unsigned($signed(v) >>> n);
  endfunction

  function automatic logic [31:0] widen(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // signed division truncating toward zero, wrapping like 32-bit hardware
  function automatic logic [31:0] div_trunc(input logic [31:0] num, input logic [31:0] den);
    logic [31:0] an, ad, q;
    an = num[31] ? -num : num;
    ad = den[31] ? -den : den;
    q  = an / ad;
    return (num[31] != den[31]) ? -q : q;
  endfunction

  function automatic reading_t compensate(input sample_t s);
    reading_t r;
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] x1, x2, x3, den, b5, t, b6, sq, b3, b4, b7, p;
    r = '{temp: '0, press: '0, press_vld: 1'b0, div_err: 1'b0};
    ac1 = widen(cal_a_signed[47:32]);
    ac2 = widen(cal_a_signed[31:16]);
    ac3 = widen(cal_a_signed[15:0]);
    ac4 = {16'd0, cal_a_unsigned[47:32]};
    ac5 = {16'd0, cal_a_unsigned[31:16]};
    ac6 = {16'd0, cal_a_unsigned[15:0]};
    b1  = widen(cal_b[31:16]);
    b2  = widen(cal_b[15:0]);
    mc  = widen(cal_m[31:16]);
    md  = widen(cal_m[15:0]);

    x1  = shr_arith(({16'd0, s.ut} - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 0) begin
      r.div_err = 1'b1;
      return r;
    end
    x2 = div_trunc(mc << 11, den);
    b5 = x1 + x2;
    t  = shr_arith(b5 + 32'd8, 4);
    if ($signed(t) > 32767) t = 32'd32767;
    else if ($signed(t) < -32768) t = 32'hFFFF_8000;
    if (!s.want) begin
      r.temp = t[15:0];
      return r;
    end

    b6 = b5 - 32'd4000;
    sq = shr_arith(b6 * b6, 12);
    x1 = shr_arith(b2 * sq, 11);
    x2 = shr_arith(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = shr_arith(ac1 * 32'd4 + x3 + 32'd2, 2);
    x1 = shr_arith(ac3 * b6, 13);
    x2 = shr_arith(b1 * sq, 16);
    x3 = shr_arith(x1 + x2 + 32'd2, 2);
    b4 = (ac4 * (x3 + 32'd32768)) >> 15;
    if (b4 == 0) begin
      r.div_err = 1'b1;
      return r;
    end
    b7 = ({16'd0, s.up} - b3) * 32'd50000;
    if (!b7[31]) p = (b7 * 32'd2) / b4;
    else         p = (b7 / b4) * 32'd2;
    x1 = shr_arith(p, 8) * shr_arith(p, 8);
    x1 = shr_arith(x1 * 32'd3038, 16);
    x2 = shr_arith(32'hFFFF_E343 * p, 16);
    p  = p + shr_arith(x1 + x2 + 32'd3791, 4);
    if ($signed(p) < 0) p = 32'd0;
    else if (p > 32'd262143) p = 32'd262143;

    r.temp      = t[15:0];
    r.press     = p[17:0];
    r.press_vld = 1'b1;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sample driver: bursts of random length, random gaps, pause markers
  // ---------------------------------------------------------------------------
  sample_t offered;
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // record the transfer that completes at this edge
      if (in_valid_i && in_ready_o) expected_readings.push_back(compensate(offered));
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_samples.size() > 0 && pending_samples[0].hold) begin
          // hold off until the pipe has drained completely
          if (expected_readings.size() == 0) void'(pending_samples.pop_front());
          in_valid_i <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          offered = pending_samples.pop_front();
          raw_temperature_i <= offered.ut;
          raw_pressure_i    <= offered.up;
          want_pressure_i   <= offered.want;
          in_valid_i        <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: stall pattern by epoch, one long hold-off to back up the pipe
  // ---------------------------------------------------------------------------
  int unsigned readings_seen = 0;
  int unsigned long_hold = 0;
  logic        long_hold_done = 1'b0;

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("%0t: %s mismatch on reading %0d: got %0d expected %0d",
             $realtime, field, readings_seen, got, want);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    reading_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected reading", $realtime);
          error_count++;
        end else begin
          e = expected_readings.pop_front();
          if (temperature_tenths_o !== e.temp)
            report_mismatch("temperature_tenths", temperature_tenths_o, e.temp);
          if (pressure_pa_o !== e.press)
            report_mismatch("pressure_pa", pressure_pa_o, e.press);
          if (pressure_valid_o !== e.press_vld)
            report_mismatch("pressure_valid", pressure_valid_o, e.press_vld);
          if (divide_error_o !== e.div_err)
            report_mismatch("divide_error", divide_error_o, e.div_err);
        end
        readings_seen++;
      end
      // start one long stall once traffic is flowing, so the input backs up
      if (!long_hold_done && readings_seen == 300) begin
        long_hold_done = 1'b1;
        long_hold = 400;
      end
      if (long_hold > 0) begin
        long_hold--;
        out_ready_i <= 1'b0;
      end else begin
        case ((cycle_count >> 8) % 3)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= (cycle_count % 4) != 0;
          default: out_ready_i <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequencing
  // ---------------------------------------------------------------------------
  task automatic add_sample(input logic [15:0] ut, input logic [15:0] up, input logic want);
    pending_samples.push_back('{hold: 1'b0, ut: ut, up: up, want: want});
  endtask

  task automatic add_pause();
    pending_samples.push_back('{hold: 1'b1, ut: '0, up: '0, want: 1'b0});
  endtask

  task automatic add_random(input int n);
    logic [15:0] ut, up;
    for (int i = 0; i < n; i++) begin
      ut = 16'($urandom());
      up = 16'($urandom());
      // push some samples to the field extremes
      if ($urandom_range(0, 15) == 0) ut = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      if ($urandom_range(0, 15) == 0) up = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      add_sample(ut, up, $urandom_range(0, 3) != 0);
    end
  endtask

  // wait until every sample is taken and every reading is back, then let the pipe go quiet;
  // sample at the falling edge so the driver's updates of this cycle are visible
  task automatic settle();
    do @(negedge clk_i);
    while (pending_samples.size() != 0 || in_valid_i || expected_readings.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_cal(input logic [1:0] idx, input logic [47:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgASigned:   cal_a_signed   = data;
      CfgAUnsigned: cal_a_unsigned = data;
      CfgBPair:     cal_b          = data[31:0];
      default:      cal_m          = data[31:0];
    endcase
  endtask

  task automatic write_all(input logic [47:0] a_s, input logic [47:0] a_u,
                           input logic [31:0] b, input logic [31:0] m);
    write_cal(CfgASigned, a_s);
    write_cal(CfgAUnsigned, a_u);
    write_cal(CfgBPair, {16'd0, b});
    write_cal(CfgMPair, {16'd0, m});
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // factory calibration: field extremes, both modes, a typical pair
    add_sample(16'h0000, 16'h0000, 1'b0);
    add_sample(16'h0000, 16'h0000, 1'b1);
    add_sample(16'hFFFF, 16'hFFFF, 1'b1);
    add_sample(16'h0000, 16'hFFFF, 1'b1);
    add_sample(16'hFFFF, 16'h0000, 1'b1);
    add_sample(16'h8000, 16'h8000, 1'b1);
    add_sample(16'h7FFF, 16'h7FFF, 1'b0);
    add_sample(16'd27898, 16'd23843, 1'b1);
    add_random(250);
    add_pause();
    add_random(350);
    settle();

    // temperature divisor zero: AC5 = 0 makes X1 = 0, MD = 0
    write_all(ASignedRst, AUnsignedRst & 48'hFFFF_0000_FFFF, BPairRst, MPairRst & 32'hFFFF_0000);
    add_sample(16'h1234, 16'h5678, 1'b1);
    add_sample(16'hFFFF, 16'h0000, 1'b0);
    add_random(20);
    settle();

    // pressure divisor zero: AC4 = 0 forces B4 = 0 whenever pressure is wanted
    write_all(ASignedRst, AUnsignedRst & 48'h0000_FFFF_FFFF, BPairRst, MPairRst);
    add_sample(16'd27898, 16'd23843, 1'b1);
    add_sample(16'd27898, 16'd23843, 1'b0);
    add_random(20);
    settle();

    // all-ones and all-zeros calibration
    write_all('1, '1, '1, '1);
    add_sample(16'h0000, 16'h0000, 1'b1);
    add_sample(16'hFFFF, 16'hFFFF, 1'b1);
    add_random(60);
    settle();
    write_all('0, '0, '0, '0);
    add_sample(16'h0000, 16'hFFFF, 1'b1);
    add_random(20);
    settle();

    // random calibrations, half near the factory values, half fully random
    for (int k = 0; k < 6; k++) begin
      if (k % 2 == 0)
        write_all(48'({$urandom(), $urandom()}), 48'({$urandom(), $urandom()}),
                  $urandom(), $urandom());
      else
        write_all(ASignedRst ^ 48'($urandom_range(0, 255)),
                  AUnsignedRst ^ 48'($urandom_range(0, 255)),
                  BPairRst ^ 32'($urandom_range(0, 255)),
                  MPairRst ^ 32'($urandom_range(0, 255)));
      add_random(170);
      if (k == 2) add_pause();
      settle();
    end

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
